@@ rtl/core/twr_pkg.sv @@
// ============================================================================
// twr_pkg
// Shared widths, codes, state types and controller/datapath interface
// structs for the timebase waveform resampler.
// ============================================================================
package twr_pkg;

    localparam int CHANNELS_DEF    = 4;
    localparam int TABLE_DEPTH_DEF = 1024;

    localparam int TIME_W     = 40;
    localparam int VALUE_W    = 32;
    localparam int PERIOD_W   = 32;
    localparam int TICK_W     = 32;
    localparam int MODES_W    = 8;
    localparam int ACT_W      = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 40;
    localparam int LCH_W      = 2;
    localparam int SIDX_W     = 10;
    localparam int ENTRY_W    = TIME_W + VALUE_W;

    localparam logic signed [TIME_W-1:0] T_MAX = {1'b0, {(TIME_W-1){1'b1}}};
    localparam logic signed [TIME_W-1:0] T_MIN = {1'b1, {(TIME_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_TIME,
        CFG_TICK_PERIOD,
        CFG_CHANNEL_MODES,
        CFG_ACTIVE_CHANNELS
    } cfg_index_t;

    typedef enum logic {
        REQ_LOAD,
        REQ_TICK
    } req_type_t;

    typedef enum logic [1:0] {
        MODE_PLAY,
        MODE_INTERP,
        MODE_NEAREST,
        MODE_ENDED
    } chan_mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PROD,
        ST_TIME,
        ST_CHAN,
        ST_PLAY_RD,
        ST_FIRST_CHK,
        ST_LAST_CHK,
        ST_E0_CHK,
        ST_E1_CHK,
        ST_INTERP,
        ST_EMIT
    } ctrl_state_t;

    typedef enum logic [2:0] {
        IP_IDLE,
        IP_PREP,
        IP_MUL,
        IP_DIV,
        IP_FIN
    } interp_state_t;

    typedef enum logic [2:0] {
        RD_CUR,
        RD_FIRST,
        RD_LASTN,
        RD_CLAMP,
        RD_IDX,
        RD_NEXT,
        RD_NEXT2
    } rd_sel_t;

    typedef enum logic [1:0] {
        VAL_ZERO,
        VAL_RD,
        VAL_NEAR,
        VAL_INTERP
    } val_sel_t;

    typedef enum logic [1:0] {
        CUR_KEEP,
        CUR_INC,
        CUR_IDX,
        CUR_IDX1
    } cur_op_t;

    typedef enum logic [1:0] {
        IDX_KEEP,
        IDX_CLAMP,
        IDX_INC
    } idx_op_t;

    typedef struct packed {
        logic     load_we;
        logic     prod_we;
        logic     time_we;
        logic     rd_en;
        rd_sel_t  rd_sel;
        logic     e0_we;
        idx_op_t  idx_op;
        cur_op_t  cur_op;
        logic     res_we;
        val_sel_t val_sel;
        logic     res_ended;
        logic     interp_start;
        logic     out_load;
    } twr_cmd_t;

    typedef struct packed {
        chan_mode_t mode;
        logic       n_zero;
        logic       cur_lt_n;
        logic       idx_zero;
        logic       idx_last;
        logic       next_last;
        logic       rd_gt_t;
        logic       rd_lt_t;
        logic       rd_le_t;
        logic       interp_done;
        logic       last_ch;
        logic       out_free;
    } twr_status_t;

endpackage

@@ rtl/core/twr_interp.sv @@
// ============================================================================
// twr_interp
// Iterative linear interpolation unit: shift-add multiply of the clamped
// time offset by the value step, then restoring division by the time gap.
// ============================================================================
module twr_interp
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [twr_pkg::TIME_W-1:0]   t,
    input  logic signed [twr_pkg::TIME_W-1:0]   t0,
    input  logic signed [twr_pkg::TIME_W-1:0]   t1,
    input  logic signed [twr_pkg::VALUE_W-1:0]  v0,
    input  logic signed [twr_pkg::VALUE_W-1:0]  v1,
    output logic                                done,
    output logic signed [twr_pkg::VALUE_W-1:0]  result
);
    import twr_pkg::*;

    localparam int DW   = TIME_W + 1;
    localparam int MW   = VALUE_W + 1;
    localparam int PW   = TIME_W + VALUE_W;
    localparam int CW   = $clog2(PW);

    interp_state_t state_reg, state_next;

    logic signed [DW-1:0]      gap_reg;
    logic signed [DW-1:0]      dt_reg;
    logic signed [MW-1:0]      dv_reg;
    logic signed [VALUE_W-1:0] v0_reg;
    logic        [MW-1:0]      mag_reg;
    logic                      neg_reg;
    logic        [PW-1:0]      acc_reg;
    logic        [TIME_W-1:0]  rem_reg;
    logic        [MW-1:0]      q_reg;
    logic        [CW-1:0]      cnt_reg;
    logic signed [VALUE_W-1:0] result_reg;
    logic                      done_reg;

    logic        [TIME_W-1:0]  gap_u;
    logic        [TIME_W-1:0]  dt_u;
    logic        [TIME_W:0]    rem_sh;
    logic                      rem_ge;
    logic signed [MW:0]        fin_sum;

    assign gap_u  = gap_reg[TIME_W-1:0];
    assign dt_u   = dt_reg[TIME_W-1:0];
    assign rem_sh = {rem_reg, acc_reg[PW-1]};
    assign rem_ge = rem_sh >= {1'b0, gap_u};
    assign fin_sum = neg_reg ? ($signed({{2{v0_reg[VALUE_W-1]}}, v0_reg}) - $signed({1'b0, q_reg}))
                             : ($signed({{2{v0_reg[VALUE_W-1]}}, v0_reg}) + $signed({1'b0, q_reg}));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            IP_IDLE: if (start) state_next = IP_PREP;
            IP_PREP: state_next = (gap_reg <= 0) ? IP_IDLE : IP_MUL;
            IP_MUL:  if (cnt_reg == '0) state_next = IP_DIV;
            IP_DIV:  if (cnt_reg == '0) state_next = IP_FIN;
            IP_FIN:  state_next = IP_IDLE;
            default: state_next = IP_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IP_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= ((state_reg == IP_PREP) && (gap_reg <= 0)) || (state_reg == IP_FIN);
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            IP_IDLE:
            begin
                gap_reg <= $signed({t1[TIME_W-1], t1}) - $signed({t0[TIME_W-1], t0});
                dt_reg  <= $signed({t[TIME_W-1], t}) - $signed({t0[TIME_W-1], t0});
                dv_reg  <= $signed({v1[VALUE_W-1], v1}) - $signed({v0[VALUE_W-1], v0});
                v0_reg  <= v0;
            end
            IP_PREP:
            begin
                if (gap_reg <= 0)
                    result_reg <= v0_reg;
                if (dt_reg < 0)
                    dt_reg <= '0;
                else if (dt_reg > gap_reg)
                    dt_reg <= gap_reg;
                neg_reg <= dv_reg[MW-1];
                mag_reg <= dv_reg[MW-1] ? MW'(-dv_reg) : MW'(dv_reg);
                acc_reg <= '0;
                cnt_reg <= CW'(MW - 1);
            end
            IP_MUL:
            begin
                acc_reg <= (acc_reg << 1) + (mag_reg[MW-1] ? PW'(dt_u) : '0);
                mag_reg <= mag_reg << 1;
                if (cnt_reg == '0)
                begin
                    cnt_reg <= CW'(PW - 1);
                    rem_reg <= '0;
                    q_reg   <= '0;
                end
                else
                    cnt_reg <= cnt_reg - 1'b1;
            end
            IP_DIV:
            begin
                acc_reg <= acc_reg << 1;
                if (rem_ge)
                    rem_reg <= TIME_W'(rem_sh - {1'b0, gap_u});
                else
                    rem_reg <= rem_sh[TIME_W-1:0];
                q_reg   <= {q_reg[MW-2:0], rem_ge};
                cnt_reg <= cnt_reg - 1'b1;
            end
            IP_FIN:
                result_reg <= fin_sum[VALUE_W-1:0];
            default: ;
        endcase
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ rtl/core/twr_datapath.sv @@
// ============================================================================
// twr_datapath
// Configuration registers, sample store, cursors, tick time, channel walk
// registers, interpolation unit and the result output register.
// ============================================================================
module twr_datapath #(
    parameter int CHANNELS    = twr_pkg::CHANNELS_DEF,
    parameter int TABLE_DEPTH = twr_pkg::TABLE_DEPTH_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  twr_pkg::twr_cmd_t                     cmd,
    output twr_pkg::twr_status_t                  status,
    input  logic [twr_pkg::LCH_W-1:0]             load_channel,
    input  logic [twr_pkg::SIDX_W-1:0]            sample_index,
    input  logic signed [twr_pkg::TIME_W-1:0]     sample_time,
    input  logic signed [twr_pkg::VALUE_W-1:0]    sample_value,
    input  logic                                  last_sample,
    input  logic                                  cfg_valid,
    input  logic [twr_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [twr_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                  out_stall,
    output logic                                  out_valid,
    output logic [twr_pkg::LCH_W-1:0]             out_channel,
    output logic signed [twr_pkg::VALUE_W-1:0]    out_value,
    output logic signed [twr_pkg::TIME_W-1:0]     tick_time,
    output logic                                  channel_ended,
    output logic                                  all_ended_event,
    output logic                                  last
);
    import twr_pkg::*;

    localparam int IDX_W     = $clog2(TABLE_DEPTH);
    localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);
    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int MEM_DEPTH = CHANNELS * (2 ** IDX_W);
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    logic signed [TIME_W-1:0]   start_reg;
    logic [PERIOD_W-1:0]        period_reg;
    logic [MODES_W-1:0]         modes_reg;
    logic [ACT_W-1:0]           active_reg;

    logic [CNT_W-1:0]           counts_reg [CHANNELS];
    logic [CNT_W-1:0]           cursor_reg [CHANNELS];
    logic [TICK_W-1:0]          tick_reg;
    logic                       notified_reg;
    logic [2*TICK_W-1:0]        prod_reg;
    logic signed [TIME_W-1:0]   t_reg;
    logic signed [TIME_W-1:0]   t_next;
    logic [CH_W-1:0]            ch_reg;
    logic                       all_reg;
    logic [IDX_W-1:0]           idx_reg;
    logic signed [TIME_W-1:0]   e0_time_reg;
    logic signed [VALUE_W-1:0]  e0_value_reg;
    logic signed [VALUE_W-1:0]  res_value_reg;
    logic                       res_ended_reg;
    logic [ENTRY_W-1:0]         rd_data_reg;

    logic                       out_valid_reg;
    logic [LCH_W-1:0]           out_channel_reg;
    logic signed [VALUE_W-1:0]  out_value_reg;
    logic signed [TIME_W-1:0]   out_time_reg;
    logic                       out_ended_reg;
    logic                       out_event_reg;
    logic                       out_last_reg;

    logic [ENTRY_W-1:0]         mem [MEM_DEPTH];

    logic [CNT_W-1:0]           n_cur;
    logic [CNT_W-1:0]           cur_cur;
    logic [CNT_W-1:0]           n_m1;
    logic [CNT_W-1:0]           idx_ext;
    logic [IDX_W-1:0]           clamp_idx;
    logic [IDX_W-1:0]           rd_idx;
    logic signed [TIME_W-1:0]   rd_time;
    logic signed [VALUE_W-1:0]  rd_value;
    logic [4:0]                 act_eff;
    logic                       last_ch;
    logic                       all_next;
    logic                       load_ok;
    logic signed [TIME_W:0]     d0;
    logic signed [TIME_W:0]     d1;
    logic signed [TIME_W+1:0]   t_sum;
    logic                       prod_over;
    logic                       interp_done;
    logic signed [VALUE_W-1:0]  interp_result;
    logic                       out_free;

    assign n_cur     = counts_reg[ch_reg];
    assign cur_cur   = cursor_reg[ch_reg];
    assign n_m1      = n_cur - 1'b1;
    assign idx_ext   = CNT_W'(idx_reg);
    assign clamp_idx = (cur_cur > n_m1) ? n_m1[IDX_W-1:0] : cur_cur[IDX_W-1:0];
    assign rd_time   = rd_data_reg[ENTRY_W-1:VALUE_W];
    assign rd_value  = rd_data_reg[VALUE_W-1:0];

    always_comb
    begin
        act_eff = 5'(active_reg);
        if (act_eff == 5'd0)
            act_eff = 5'd1;
        if (act_eff > 5'(CHANNELS))
            act_eff = 5'(CHANNELS);
    end

    assign last_ch  = (5'(ch_reg) == (act_eff - 5'd1));
    assign all_next = all_reg & res_ended_reg;
    assign out_free = !out_valid_reg || !out_stall;
    assign load_ok  = (32'(load_channel) < CHANNELS) && (32'(sample_index) < TABLE_DEPTH);

    assign d0 = $signed({t_reg[TIME_W-1], t_reg}) - $signed({e0_time_reg[TIME_W-1], e0_time_reg});
    assign d1 = $signed({rd_time[TIME_W-1], rd_time}) - $signed({t_reg[TIME_W-1], t_reg});

    // tick time with saturation
    assign prod_over = (prod_reg[2*TICK_W-1:TIME_W+1] != '0)
                    || (prod_reg[TIME_W] && (prod_reg[TIME_W-1:0] != '0));
    assign t_sum = $signed({{2{start_reg[TIME_W-1]}}, start_reg})
                 + $signed({1'b0, prod_reg[TIME_W:0]});

    always_comb
    begin
        if (prod_over)
            t_next = T_MAX;
        else if ((t_sum[TIME_W+1:TIME_W-1] == 3'b000) || (t_sum[TIME_W+1:TIME_W-1] == 3'b111))
            t_next = t_sum[TIME_W-1:0];
        else if (t_sum[TIME_W+1])
            t_next = T_MIN;
        else
            t_next = T_MAX;
    end

    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_CUR:   rd_idx = cur_cur[IDX_W-1:0];
            RD_FIRST: rd_idx = '0;
            RD_LASTN: rd_idx = n_m1[IDX_W-1:0];
            RD_CLAMP: rd_idx = clamp_idx;
            RD_IDX:   rd_idx = idx_reg;
            RD_NEXT:  rd_idx = idx_reg + 1'b1;
            RD_NEXT2: rd_idx = idx_reg + 2'd2;
            default:  rd_idx = idx_reg;
        endcase
    end

    // sample store
    always_ff @(posedge clk)
    begin
        if (cmd.load_we && load_ok)
            mem[ADDR_W'({CH_W'(load_channel), IDX_W'(sample_index)})] <= {sample_time, sample_value};
        if (cmd.rd_en)
            rd_data_reg <= mem[ADDR_W'({ch_reg, rd_idx})];
    end

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg  <= '0;
            period_reg <= PERIOD_W'(1000);
            modes_reg  <= '0;
            active_reg <= ACT_W'(4);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_START_TIME:      start_reg  <= cfg_data[TIME_W-1:0];
                CFG_TICK_PERIOD:     period_reg <= cfg_data[PERIOD_W-1:0];
                CFG_CHANNEL_MODES:   modes_reg  <= cfg_data[MODES_W-1:0];
                CFG_ACTIVE_CHANNELS: active_reg <= cfg_data[ACT_W-1:0];
                default: ;
            endcase
        end
    end

    // counts and cursors
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                counts_reg[i] <= '0;
                cursor_reg[i] <= '0;
            end
        end
        else if (cmd.load_we)
        begin
            if (load_ok && last_sample)
            begin
                counts_reg[CH_W'(load_channel)] <= CNT_W'(32'(sample_index) + 32'd1);
                cursor_reg[CH_W'(load_channel)] <= '0;
            end
        end
        else
        begin
            case (cmd.cur_op)
                CUR_INC:  cursor_reg[ch_reg] <= cur_cur + 1'b1;
                CUR_IDX:  cursor_reg[ch_reg] <= idx_ext;
                CUR_IDX1: cursor_reg[ch_reg] <= idx_ext + 1'b1;
                default: ;
            endcase
        end
    end

    // tick control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg     <= '0;
            notified_reg <= 1'b0;
            ch_reg       <= '0;
            all_reg      <= 1'b0;
        end
        else if (cmd.time_we)
        begin
            ch_reg  <= '0;
            all_reg <= 1'b1;
        end
        else if (cmd.out_load)
        begin
            all_reg <= all_next;
            if (last_ch)
            begin
                tick_reg     <= tick_reg + 1'b1;
                notified_reg <= all_next;
            end
            else
                ch_reg <= ch_reg + 1'b1;
        end
    end

    // walk and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.prod_we)
            prod_reg <= tick_reg * period_reg;
        if (cmd.time_we)
            t_reg <= t_next;
        if (cmd.e0_we)
        begin
            e0_time_reg  <= rd_time;
            e0_value_reg <= rd_value;
        end
        case (cmd.idx_op)
            IDX_CLAMP: idx_reg <= clamp_idx;
            IDX_INC:   idx_reg <= idx_reg + 1'b1;
            default: ;
        endcase
        if (cmd.res_we)
        begin
            res_ended_reg <= cmd.res_ended;
            case (cmd.val_sel)
                VAL_RD:     res_value_reg <= rd_value;
                VAL_NEAR:   res_value_reg <= (d0 < d1) ? e0_value_reg : rd_value;
                VAL_INTERP: res_value_reg <= interp_result;
                default:    res_value_reg <= '0;
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_channel_reg <= LCH_W'(ch_reg);
            out_value_reg   <= res_value_reg;
            out_time_reg    <= t_reg;
            out_ended_reg   <= res_ended_reg;
            out_event_reg   <= last_ch && all_next && !notified_reg;
            out_last_reg    <= last_ch;
        end
    end

    twr_interp u_interp
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.interp_start),
        .t      (t_reg),
        .t0     (e0_time_reg),
        .t1     (rd_time),
        .v0     (e0_value_reg),
        .v1     (rd_value),
        .done   (interp_done),
        .result (interp_result)
    );

    always_comb
    begin
        status.mode        = (5'(ch_reg) < 5'd4) ? chan_mode_t'(modes_reg[{ch_reg, 1'b0} +: 2])
                                                 : MODE_PLAY;
        status.n_zero      = (n_cur == '0);
        status.cur_lt_n    = (cur_cur < n_cur);
        status.idx_zero    = (idx_reg == '0);
        status.idx_last    = (idx_ext == n_m1);
        status.next_last   = ((idx_ext + 1'b1) == n_m1);
        status.rd_gt_t     = (rd_time > t_reg);
        status.rd_lt_t     = (rd_time < t_reg);
        status.rd_le_t     = (rd_time <= t_reg);
        status.interp_done = interp_done;
        status.last_ch     = last_ch;
        status.out_free    = out_free;
    end

    assign out_valid       = out_valid_reg;
    assign out_channel     = out_channel_reg;
    assign out_value       = out_value_reg;
    assign tick_time       = out_time_reg;
    assign channel_ended   = out_ended_reg;
    assign all_ended_event = out_event_reg;
    assign last            = out_last_reg;

endmodule

@@ rtl/core/twr_ctrl.sv @@
// ============================================================================
// twr_ctrl
// Request sequencer: accepts load and tick requests, walks the served
// channels and drives the datapath command bundle.
// ============================================================================
module twr_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  req_type,
    input  twr_pkg::twr_status_t  status,
    output twr_pkg::twr_cmd_t     cmd
);
    import twr_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        adv;

    assign adv = (status.mode == MODE_INTERP) ? status.rd_lt_t : status.rd_le_t;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid && (req_type == REQ_TICK))
                    state_next = ST_PROD;
            ST_PROD: state_next = ST_TIME;
            ST_TIME: state_next = ST_CHAN;
            ST_CHAN:
            begin
                unique case (status.mode)
                    MODE_PLAY:    state_next = status.cur_lt_n ? ST_PLAY_RD : ST_EMIT;
                    MODE_INTERP:  state_next = status.n_zero ? ST_EMIT : ST_FIRST_CHK;
                    MODE_NEAREST: state_next = status.n_zero ? ST_EMIT : ST_E0_CHK;
                    default:      state_next = ST_EMIT;
                endcase
            end
            ST_PLAY_RD:   state_next = ST_EMIT;
            ST_FIRST_CHK: state_next = status.rd_gt_t ? ST_EMIT : ST_LAST_CHK;
            ST_LAST_CHK:  state_next = status.rd_lt_t ? ST_EMIT : ST_E0_CHK;
            ST_E0_CHK:    state_next = status.idx_last ? ST_EMIT
                                     : (((status.mode == MODE_NEAREST) && status.idx_zero
                                         && status.rd_gt_t) ? ST_EMIT : ST_E1_CHK);
            ST_E1_CHK:
            begin
                if (adv)
                    state_next = status.next_last ? ST_EMIT : ST_E1_CHK;
                else
                    state_next = (status.mode == MODE_INTERP) ? ST_INTERP : ST_EMIT;
            end
            ST_INTERP:
                if (status.interp_done)
                    state_next = ST_EMIT;
            ST_EMIT:
                if (status.out_free)
                    state_next = status.last_ch ? ST_IDLE : ST_CHAN;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE: cmd.load_we = in_valid && (req_type == REQ_LOAD);
            ST_PROD: cmd.prod_we = 1'b1;
            ST_TIME: cmd.time_we = 1'b1;
            ST_CHAN:
            begin
                unique case (status.mode)
                    MODE_PLAY:
                    begin
                        if (status.cur_lt_n)
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_CUR;
                        end
                        else
                        begin
                            cmd.res_we    = 1'b1;
                            cmd.res_ended = 1'b1;
                        end
                    end
                    MODE_INTERP, MODE_NEAREST:
                    begin
                        if (status.n_zero)
                        begin
                            cmd.res_we    = 1'b1;
                            cmd.res_ended = 1'b1;
                        end
                        else
                        begin
                            cmd.idx_op = IDX_CLAMP;
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = (status.mode == MODE_INTERP) ? RD_FIRST : RD_CLAMP;
                        end
                    end
                    default:
                    begin
                        cmd.res_we    = 1'b1;
                        cmd.res_ended = 1'b1;
                    end
                endcase
            end
            ST_PLAY_RD:
            begin
                cmd.res_we  = 1'b1;
                cmd.val_sel = VAL_RD;
                cmd.cur_op  = CUR_INC;
            end
            ST_FIRST_CHK:
            begin
                if (status.rd_gt_t)
                    cmd.res_we = 1'b1;
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_LASTN;
                end
            end
            ST_LAST_CHK:
            begin
                if (status.rd_lt_t)
                begin
                    cmd.res_we    = 1'b1;
                    cmd.res_ended = 1'b1;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_IDX;
                end
            end
            ST_E0_CHK:
            begin
                cmd.e0_we = 1'b1;
                if ((status.mode == MODE_NEAREST) && status.idx_zero && status.rd_gt_t)
                    cmd.res_we = 1'b1;
                else if ((status.mode == MODE_NEAREST) && status.idx_last && status.rd_lt_t)
                begin
                    cmd.res_we    = 1'b1;
                    cmd.res_ended = 1'b1;
                end
                else if (status.idx_last)
                begin
                    cmd.res_we  = 1'b1;
                    cmd.val_sel = VAL_RD;
                    cmd.cur_op  = CUR_IDX;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_NEXT;
                end
            end
            ST_E1_CHK:
            begin
                if (adv)
                begin
                    cmd.idx_op = IDX_INC;
                    cmd.e0_we  = 1'b1;
                    if (status.next_last)
                    begin
                        cmd.res_we  = 1'b1;
                        cmd.val_sel = VAL_RD;
                        cmd.cur_op  = CUR_IDX1;
                    end
                    else
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_NEXT2;
                    end
                end
                else if (status.mode == MODE_INTERP)
                    cmd.interp_start = 1'b1;
                else
                begin
                    cmd.res_we  = 1'b1;
                    cmd.val_sel = VAL_NEAR;
                    cmd.cur_op  = CUR_IDX;
                end
            end
            ST_INTERP:
            begin
                if (status.interp_done)
                begin
                    cmd.res_we  = 1'b1;
                    cmd.val_sel = VAL_INTERP;
                    cmd.cur_op  = CUR_IDX;
                end
            end
            ST_EMIT: cmd.out_load = status.out_free;
            default: ;
        endcase
    end

    assign in_stall = (state_reg != ST_IDLE);

endmodule

@@ rtl/core/timebase_waveform_resampler_top.sv @@
// ============================================================================
// timebase_waveform_resampler_top
// Per-channel sample tables replayed against a tick timebase, as is, by
// linear interpolation or by nearest sample.
// ============================================================================
// A load request writes one sample while the block stays idle, so the next
// request is not held off. A tick request forms the saturated tick time and
// then serves each channel in turn: modes 0 and 3 need at most one table read,
// nearest and interpolation read around the tick time, one more read for
// every sample the cursor walks over, and an interpolation adds 33 multiply
// steps and 72 divide steps in the shared interpolation unit; the sample
// memory's single read port sets the walk. A tick's results leave through an
// output register, so the next request is taken while the final result waits.
module timebase_waveform_resampler_top #(
    parameter int CHANNELS    = twr_pkg::CHANNELS_DEF,
    parameter int TABLE_DEPTH = twr_pkg::TABLE_DEPTH_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  req_type,
    input  logic [twr_pkg::LCH_W-1:0]             load_channel,
    input  logic [twr_pkg::SIDX_W-1:0]            sample_index,
    input  logic signed [twr_pkg::TIME_W-1:0]     sample_time,
    input  logic signed [twr_pkg::VALUE_W-1:0]    sample_value,
    input  logic                                  last_sample,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [twr_pkg::LCH_W-1:0]             out_channel,
    output logic signed [twr_pkg::VALUE_W-1:0]    out_value,
    output logic signed [twr_pkg::TIME_W-1:0]     tick_time,
    output logic                                  channel_ended,
    output logic                                  all_ended_event,
    output logic                                  last,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [twr_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [twr_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import twr_pkg::*;

    twr_cmd_t    cmd;
    twr_status_t status;

    assign cfg_ready = 1'b1;

    twr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .req_type (req_type),
        .status   (status),
        .cmd      (cmd)
    );

    twr_datapath #(
        .CHANNELS    (CHANNELS),
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .load_channel    (load_channel),
        .sample_index    (sample_index),
        .sample_time     (sample_time),
        .sample_value    (sample_value),
        .last_sample     (last_sample),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .out_channel     (out_channel),
        .out_value       (out_value),
        .tick_time       (tick_time),
        .channel_ended   (channel_ended),
        .all_ended_event (all_ended_event),
        .last            (last)
    );

endmodule
